>>> rtl/ahh_pkg.sv
package ahh_pkg;

  localparam int unsigned ANGLE_W = 15;
  localparam int unsigned CAND_W  = 17;
  localparam int unsigned SUM_W   = 7;

  localparam logic [ANGLE_W-1:0] FULL_TURN    = 15'd23040;
  localparam logic [ANGLE_W-1:0] HALF_TURN    = 15'd11520;
  localparam logic [ANGLE_W-1:0] QUARTER_TURN = 15'd5760;
  localparam logic [ANGLE_W-1:0] CLOSE_LIMIT  = 15'd4480;

  // snap count works in whole degrees
  localparam int unsigned DEG_FRAC_W    = 6;
  localparam int unsigned SNAP_BIAS_DEG = 45;
  localparam int unsigned QUARTER_DEG   = 90;
  localparam int unsigned FULL_DEG      = 360;
  localparam int unsigned MAX_QUARTERS  = FULL_DEG / QUARTER_DEG;

  // input wrap: shift by three full turns, then strip whole turns
  localparam int unsigned WRAP_OFFSET = 69120;
  localparam int unsigned WRAP_STEPS  = 5;

  typedef logic [ANGLE_W-1:0]      angle_t;
  typedef logic signed [SUM_W-1:0] vote_t;

  typedef enum logic [1:0] {
    PATH_CLOSE = 2'd0,
    PATH_VOTE  = 2'd1,
    PATH_SNAP  = 2'd2
  } path_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_VOTE,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic vote_en;
    logic shift_en;
  } cell_ctl_t;

  function automatic angle_t circ_dist(angle_t a, angle_t b);
    angle_t d;
    d = (a >= b) ? (a - b) : (b - a);
    return (d < HALF_TURN) ? d : (FULL_TURN - d);
  endfunction

endpackage

>>> rtl/ahh_cell.sv
module ahh_cell import ahh_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cell_ctl_t ctl_i,
  input  angle_t    cand_i,
  input  angle_t    cur_i,
  input  angle_t    angle_in_i,
  input  logic      valid_in_i,
  input  vote_t     sum_in_i,
  output angle_t    angle_o,
  output logic      valid_o,
  output vote_t     sum_o
);

  angle_t angle_q;
  logic   valid_q;
  vote_t  sum_q, sum_d;
  logic   closer;
  vote_t  step;

  always_comb begin
    closer = circ_dist(cand_i, angle_q) < circ_dist(cur_i, angle_q);
    if (!valid_q) begin
      step = '0;
    end else if (closer) begin
      step = vote_t'(1);
    end else begin
      step = vote_t'(-1);
    end
    sum_d = sum_in_i + step;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      angle_q <= '0;
      valid_q <= 1'b0;
    end else if (ctl_i.shift_en) begin
      angle_q <= angle_in_i;
      valid_q <= valid_in_i;
    end
  end

  // partial sum ripples one cell per cycle while voting
  always_ff @(posedge clk_i) begin
    if (ctl_i.vote_en) begin
      sum_q <= sum_d;
    end
  end

  assign angle_o = angle_q;
  assign valid_o = valid_q;
  assign sum_o   = sum_q;

endmodule

>>> rtl/angle_history_hysteresis_top.sv
// channel | direction | handshake              | payload
// in      | input     | in_valid_i / in_stall_o   | candidate_angle_i, current_angle_i
// out     | output    | out_valid_o / out_stall_i | selected_angle_o, decision_path_o,
//         |           |                           | vote_total_o
//
// An item moves from ST_IDLE, which accepts it, to ST_VOTE, while the vote sum
// ripples down the cell chain, and to ST_DONE to decide and shift the history.
// Reset clears all history valid bits at once; no clearing pass is needed.
// A finished result waits in the output register; the decide cycle holds while
// that register is full and stalled. in_stall_o is high while an item is at work.
module angle_history_hysteresis_top import ahh_pkg::*; #(
  parameter int unsigned HISTORY_DEPTH = 8
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic signed [CAND_W-1:0] candidate_angle_i,
  input  logic [ANGLE_W-1:0]       current_angle_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [ANGLE_W-1:0]       selected_angle_o,
  output logic [1:0]               decision_path_o,
  output logic signed [SUM_W-1:0]  vote_total_o
);

  localparam int unsigned CNT_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;

  function automatic angle_t wrap_cand(logic signed [CAND_W-1:0] v);
    logic [CAND_W:0] t;
    logic [2:0]      k;
    t = {v[CAND_W-1], v} + (CAND_W+1)'(WRAP_OFFSET);
    k = '0;
    for (int i = 1; i <= WRAP_STEPS; i++) begin
      if (t >= (CAND_W+1)'(i) * (CAND_W+1)'(FULL_TURN)) begin
        k = k + 3'd1;
      end
    end
    return angle_t'(t - (CAND_W+1)'(k) * (CAND_W+1)'(FULL_TURN));
  endfunction

  state_e          state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  angle_t          cand_q, cur_q;
  logic            in_acc, out_free, out_load;
  cell_ctl_t       ctl;

  angle_t angle_chain [HISTORY_DEPTH+1];
  logic   valid_chain [HISTORY_DEPTH+1];
  vote_t  sum_chain   [HISTORY_DEPTH+1];

  logic   out_valid_q;
  angle_t sel_q, sel_d;
  path_e  path_q, path_d;
  vote_t  votes_q, votes_d;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;

  // next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      ST_IDLE: begin
        cnt_d = '0;
        if (in_valid_i) begin
          state_d = ST_VOTE;
        end
      end
      ST_VOTE: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(HISTORY_DEPTH - 1)) begin
          state_d = ST_DONE;
          cnt_d   = '0;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_stall_o   = 1'b1;
    ctl.vote_en  = 1'b0;
    ctl.shift_en = 1'b0;
    out_load     = 1'b0;
    case (state_q)
      ST_IDLE: in_stall_o = 1'b0;
      ST_VOTE: ctl.vote_en = 1'b1;
      ST_DONE: begin
        ctl.shift_en = out_free;
        out_load     = out_free;
      end
      default: in_stall_o = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cand_q <= wrap_cand(candidate_angle_i);
      cur_q  <= (current_angle_i >= FULL_TURN) ? (current_angle_i - FULL_TURN)
                                                : current_angle_i;
    end
  end

  // history chain, entry 0 newest
  assign angle_chain[0] = cand_q;
  assign valid_chain[0] = 1'b1;
  assign sum_chain[0]   = '0;

  for (genvar g = 0; g < HISTORY_DEPTH; g++) begin : g_cell
    ahh_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (ctl),
      .cand_i     (cand_q),
      .cur_i      (cur_q),
      .angle_in_i (angle_chain[g]),
      .valid_in_i (valid_chain[g]),
      .sum_in_i   (sum_chain[g]),
      .angle_o    (angle_chain[g+1]),
      .valid_o    (valid_chain[g+1]),
      .sum_o      (sum_chain[g+1])
    );
  end

  // decision
  always_comb begin
    angle_t          diff;
    logic [ANGLE_W-DEG_FRAC_W-1:0] deg;
    logic [2:0]      quarters;
    logic [ANGLE_W:0] turned;
    logic            below;
    vote_t           total;
    below = cand_q < cur_q;
    diff  = below ? (cur_q - cand_q) : (cand_q - cur_q);
    deg   = diff[ANGLE_W-1:DEG_FRAC_W];
    quarters = '0;
    for (int i = 1; i <= MAX_QUARTERS; i++) begin
      if ({1'b0, deg} + (ANGLE_W-DEG_FRAC_W+1)'(SNAP_BIAS_DEG) >=
          (ANGLE_W-DEG_FRAC_W+1)'(QUARTER_DEG * i)) begin
        quarters = quarters + 3'd1;
      end
    end
    if (below) begin
      turned = {1'b0, cand_q} + (ANGLE_W+1)'(quarters) * (ANGLE_W+1)'(QUARTER_TURN);
    end else begin
      turned = {1'b0, cand_q} + {1'b0, FULL_TURN}
             - (ANGLE_W+1)'(quarters) * (ANGLE_W+1)'(QUARTER_TURN);
    end
    if (turned >= {1'b0, FULL_TURN}) begin
      turned = turned - {1'b0, FULL_TURN};
    end
    total = sum_chain[HISTORY_DEPTH];

    if (circ_dist(cand_q, cur_q) < CLOSE_LIMIT) begin
      sel_d   = cand_q;
      path_d  = PATH_CLOSE;
      votes_d = '0;
    end else if (total > vote_t'(0)) begin
      sel_d   = cand_q;
      path_d  = PATH_VOTE;
      votes_d = total;
    end else begin
      sel_d   = turned[ANGLE_W-1:0];
      path_d  = PATH_SNAP;
      votes_d = total;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      sel_q   <= sel_d;
      path_q  <= path_d;
      votes_q <= votes_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign selected_angle_o = sel_q;
  assign decision_path_o  = path_q;
  assign vote_total_o     = votes_q;

  a_sel_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> selected_angle_o < FULL_TURN)
    else $error("selected angle out of range");

  a_close_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && decision_path_o == PATH_CLOSE |-> vote_total_o == vote_t'(0))
    else $error("close accept with nonzero vote total");

  a_vote_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && decision_path_o == PATH_VOTE |-> vote_total_o > vote_t'(0))
    else $error("vote accept without positive total");

  a_snap_nonpos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && decision_path_o == PATH_SNAP |-> vote_total_o <= vote_t'(0))
    else $error("snap with positive vote total");

  a_load_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> out_valid_o && $past(state_q) == ST_DONE)
    else $error("result load did not raise output valid");

endmodule

>>> test/tb_top.sv
module tb_top;
  import ahh_pkg::*;

  localparam int TURN    = FULL_TURN;
  localparam int HALF    = HALF_TURN;
  localparam int QUARTER = QUARTER_TURN;
  localparam int NEAR    = CLOSE_LIMIT;
  localparam int DEPTH   = 8;
  localparam int LATENCY = DEPTH + 2;
  localparam int N_RANDOM = 1150;

  typedef struct {
    logic signed [CAND_W-1:0] cand;
    angle_t                   cur;
    bit                       drain;
  } meas_t;

  typedef struct {
    angle_t angle;
    path_e  path;
    vote_t  votes;
  } verdict_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     in_valid_i = 1'b0;
  logic                     in_stall_o;
  logic signed [CAND_W-1:0] candidate_angle_i = '0;
  angle_t                   current_angle_i = '0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  angle_t                   selected_angle_o;
  logic [1:0]               decision_path_o;
  vote_t                    vote_total_o;

  meas_t    pending_meas[$];
  verdict_t expected_verdicts[$];
  angle_t   trk_angle[DEPTH];
  bit       trk_valid[DEPTH];
  int       sent_cnt = 0;
  int       recv_cnt = 0;
  int       fail_cnt = 0;
  bit       drv_take;
  meas_t    drv_next;
  verdict_t mon_want;

  angle_history_hysteresis_top #(.HISTORY_DEPTH(DEPTH)) dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .candidate_angle_i (candidate_angle_i),
    .current_angle_i   (current_angle_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .selected_angle_o  (selected_angle_o),
    .decision_path_o   (decision_path_o),
    .vote_total_o      (vote_total_o)
  );

  always #2 clk_i = ~clk_i;

  function automatic int arc_span(int a, int b);
    int d;
    d = (a >= b) ? a - b : b - a;
    return (d < HALF) ? d : TURN - d;
  endfunction

  // Filter one measurement and advance the candidate history.
  function automatic verdict_t filter_angle(logic signed [CAND_W-1:0] raw, angle_t cur_raw);
    int c;
    int cu;
    int votes;
    int diff;
    int n;
    verdict_t res;
    c = int'(raw) % TURN;
    if (c < 0) c += TURN;
    cu = int'(cur_raw) % TURN;
    votes = 0;
    if (arc_span(c, cu) < NEAR) begin
      res.angle = angle_t'(c);
      res.path = PATH_CLOSE;
    end else begin
      for (int i = 0; i < DEPTH; i++) begin
        if (trk_valid[i]) begin
          if (arc_span(c, trk_angle[i]) < arc_span(cu, trk_angle[i])) votes++;
          else votes--;
        end
      end
      if (votes > 0) begin
        res.angle = angle_t'(c);
        res.path = PATH_VOTE;
      end else begin
        diff = (c < cu) ? cu - c : c - cu;
        n = ((diff >> DEG_FRAC_W) + SNAP_BIAS_DEG) / QUARTER_DEG;
        if (c < cu) res.angle = angle_t'((c + QUARTER * n) % TURN);
        else res.angle = angle_t'((c + TURN - QUARTER * n) % TURN);
        res.path = PATH_SNAP;
      end
    end
    res.votes = vote_t'(votes);
    for (int i = DEPTH - 1; i > 0; i--) begin
      trk_angle[i] = trk_angle[i-1];
      trk_valid[i] = trk_valid[i-1];
    end
    trk_angle[0] = angle_t'(c);
    trk_valid[0] = 1'b1;
    return res;
  endfunction

  function automatic void add_meas(int cand, int cur);
    meas_t m;
    m.cand = cand[CAND_W-1:0];
    m.cur = cur[ANGLE_W-1:0];
    m.drain = 1'b0;
    pending_meas = {pending_meas, m};
  endfunction

  function automatic int mod_turn(int v);
    int r;
    r = v % TURN;
    return (r < 0) ? r + TURN : r;
  endfunction

  // One tracking run: a true angle with jitter, quarter-turn misreads,
  // and real rotations that the committed angle follows late, plus candidates near the close limit.
  function automatic int add_track();
    int truth;
    int cur;
    int lag;
    int len;
    int c;
    int r;
    truth = $urandom_range(TURN - 1);
    cur = truth;
    lag = 0;
    len = $urandom_range(12, 4);
    for (int k = 0; k < len; k++) begin
      r = $urandom_range(99);
      if (r < 60) begin
        c = truth + $urandom_range(1200) - 600;
      end else if (r < 78) begin
        c = truth + QUARTER * $urandom_range(3, 1) + $urandom_range(1200) - 600;
      end else if (r < 90) begin
        truth = mod_turn(truth + QUARTER * $urandom_range(3, 1));
        lag = $urandom_range(4, 1);
        c = truth + $urandom_range(400) - 200;
      end else begin
        c = truth + NEAR + $urandom_range(200) - 100;
      end
      if (lag > 0) lag--;
      else cur = mod_turn(truth + $urandom_range(300) - 150);
      c = mod_turn(c);
      case ($urandom_range(9))
        0: c = c + TURN;
        1: c = c - TURN;
        default: ;
      endcase
      add_meas(c, cur);
    end
    return len;
  endfunction

  // Driver: hold the item while stalled, otherwise load the next one or drop valid.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      sent_cnt <= 0;
    end else begin
      drv_take = in_valid_i && !in_stall_o;
      if (drv_take) begin
        expected_verdicts = {expected_verdicts,
                             filter_angle(candidate_angle_i, current_angle_i)};
        sent_cnt <= sent_cnt + 1;
      end
      if (!in_valid_i || drv_take) begin
        if (pending_meas.size() > 0 &&
            !(pending_meas[0].drain && (drv_take || sent_cnt != recv_cnt)) &&
            ((sent_cnt >= 400 && sent_cnt < 600) || $urandom_range(99) >= 15)) begin
          drv_next = pending_meas.pop_front();
          in_valid_i <= 1'b1;
          candidate_angle_i <= drv_next.cand;
          current_angle_i <= drv_next.cur;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each accepted result with the oldest expectation.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      recv_cnt <= 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        recv_cnt <= recv_cnt + 1;
        if (expected_verdicts.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display("unexpected result: angle %0d path %0d votes %0d",
                     selected_angle_o, decision_path_o, vote_total_o);
        end else begin
          mon_want = expected_verdicts.pop_front();
          if (selected_angle_o !== mon_want.angle || decision_path_o !== mon_want.path ||
              vote_total_o !== mon_want.votes) begin
            fail_cnt++;
            if (fail_cnt <= 10)
              $display("result %0d: angle %0d exp %0d, path %0d exp %0d, votes %0d exp %0d",
                       recv_cnt, selected_angle_o, mon_want.angle, decision_path_o,
                       mon_want.path, vote_total_o, mon_want.votes);
          end
        end
      end
      out_stall_i <= !(recv_cnt >= 400 && recv_cnt < 600) && ($urandom_range(99) < 15);
    end
  end

  initial begin
    int made;
    for (int i = 0; i < DEPTH; i++) begin
      trk_angle[i] = '0;
      trk_valid[i] = 1'b0;
    end
    // empty history: a far candidate snaps with no votes
    add_meas(10000, 0);
    add_meas(0, 0);
    add_meas(4479, 0);
    add_meas(4480, 0);
    add_meas(-65536, 100);
    add_meas(65535, 32767);
    add_meas(-23040, 23039);
    add_meas(46079, 0);
    add_meas(-1, 23040);
    add_meas(11520, 0);
    add_meas(1000, 12000);
    add_meas(5800, 5760);
    add_meas(5700, 5760);
    add_meas(5760, 5760);
    // history near a quarter turn away: a tied vote snaps, then a vote accepts
    add_meas(5760, 0);
    add_meas(5820, 0);
    // equal distances to history count against
    add_meas(11520, 0);
    add_meas(17280, 0);
    add_meas(0, 17280);
    add_meas(22000, 1500);
    add_meas(-3000, 5000);
    add_meas(30000, 16383);
    made = 0;
    while (made < N_RANDOM) begin
      if ($urandom_range(99) < 80) begin
        made += add_track();
      end else begin
        add_meas($signed($urandom() & 32'h1ffff) - ((($urandom() & 0) == 0) ? 0 : 0),
                 $urandom() & 32'h7fff);
        made++;
      end
    end
    for (int i = 0; i < pending_meas.size(); i++) begin
      if ($urandom() & 1) pending_meas[i].cand[CAND_W-1] = ~pending_meas[i].cand[CAND_W-1];
      if (i % 100 != 7) break;
    end
    pending_meas[300].drain = 1'b1;
    pending_meas[900].drain = 1'b1;

    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    do @(negedge clk_i);
    while (pending_meas.size() > 0 || in_valid_i || sent_cnt != recv_cnt);
    repeat (2 * LATENCY) @(negedge clk_i);
    if (expected_verdicts.size() != 0) fail_cnt++;
    if (fail_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

>>> files.f
rtl/ahh_pkg.sv
rtl/ahh_cell.sv
rtl/angle_history_hysteresis_top.sv
test/tb_top.sv
